// ----- sv/deq_pkg.sv -----
// deq_pkg: shared types and constants of the double-ended queue
// operation and status codes, result flags passed from control to top level
// no dependencies
package deq_pkg;

  localparam int DEPTH_DEF      = 16;
  localparam int DATA_WIDTH_DEF = 32;
  localparam int VALUE_W        = 32;
  localparam int DATA_OUT_W     = 32;
  localparam int MODE_W         = 3;
  localparam int STATUS_W       = 2;

  typedef enum logic [MODE_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_REAR  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_REAR   = 3'd3,
    OP_PEEK_FRONT = 3'd4,
    OP_PEEK_REAR  = 3'd5,
    OP_CLEAR      = 3'd6
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // what the last accepted operation left for the result beat
  typedef struct packed {
    status_t status;
    logic    rd;    // data comes from the store read
    logic    err;   // empty error, data reads as all ones
  } res_info_t;

endpackage

// ----- sv/deq_ram.sv -----
// deq_ram: generic single-write, single-read synchronous RAM
// read data registered, held while rd_en is low
// no dependencies
module deq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- sv/deq_ctrl.sv -----
// deq_ctrl: front/rear index and count registers of the deque
// decodes each operation into store read and write requests
// depends on deq_pkg
module deq_ctrl #(
  parameter int DEPTH      = deq_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = deq_pkg::DATA_WIDTH_DEF,
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          op_en,
  input  logic [deq_pkg::MODE_W-1:0]    mode,
  input  logic [deq_pkg::VALUE_W-1:0]   value,
  output logic                          wr_en,
  output logic [IDX_W-1:0]              wr_addr,
  output logic [DATA_WIDTH-1:0]         wr_data,
  output logic                          rd_en,
  output logic [IDX_W-1:0]              rd_addr,
  output deq_pkg::res_info_t            info,
  output logic [CNT_W-1:0]              count
);

  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  logic [IDX_W-1:0] front, front_next;
  logic [IDX_W-1:0] rear, rear_next;
  logic [CNT_W-1:0] count_next;
  deq_pkg::res_info_t info_next;

  logic [IDX_W-1:0] front_inc, front_dec, rear_inc, rear_dec;
  logic             is_empty, is_full;

  // word as stored: sign-extended or cut to the store width
  generate
    if (DATA_WIDTH > deq_pkg::VALUE_W) begin : g_wide
      assign wr_data = {{(DATA_WIDTH - deq_pkg::VALUE_W){value[deq_pkg::VALUE_W-1]}}, value};
    end else begin : g_narrow
      assign wr_data = value[DATA_WIDTH-1:0];
    end
  endgenerate

  assign is_empty  = (count == '0);
  assign is_full   = (count == CNT_FULL);
  assign front_inc = (front == IDX_LAST) ? '0 : front + 1'b1;
  assign front_dec = (front == '0) ? IDX_LAST : front - 1'b1;
  assign rear_inc  = (rear == IDX_LAST) ? '0 : rear + 1'b1;
  assign rear_dec  = (rear == '0) ? IDX_LAST : rear - 1'b1;

  always_comb begin
    front_next       = front;
    rear_next        = rear;
    count_next       = count;
    info_next.status = deq_pkg::ST_OK;
    info_next.rd     = 1'b0;
    info_next.err    = 1'b0;
    wr_en            = 1'b0;
    wr_addr          = rear;
    rd_en            = 1'b0;
    rd_addr          = front;
    case (deq_pkg::op_t'(mode))
      deq_pkg::OP_PUSH_FRONT: begin
        if (is_full) begin
          info_next.status = deq_pkg::ST_FULL;
        end else begin
          wr_en      = op_en;
          wr_addr    = front_dec;
          front_next = front_dec;
          count_next = count + 1'b1;
        end
      end
      deq_pkg::OP_PUSH_REAR: begin
        if (is_full) begin
          info_next.status = deq_pkg::ST_FULL;
        end else begin
          wr_en      = op_en;
          wr_addr    = rear;
          rear_next  = rear_inc;
          count_next = count + 1'b1;
        end
      end
      deq_pkg::OP_POP_FRONT, deq_pkg::OP_PEEK_FRONT: begin
        if (is_empty) begin
          info_next.status = deq_pkg::ST_EMPTY;
          info_next.err    = 1'b1;
        end else begin
          rd_en        = op_en;
          rd_addr      = front;
          info_next.rd = 1'b1;
          if (mode == deq_pkg::OP_POP_FRONT) begin
            front_next = front_inc;
            count_next = count - 1'b1;
          end
        end
      end
      deq_pkg::OP_POP_REAR, deq_pkg::OP_PEEK_REAR: begin
        if (is_empty) begin
          info_next.status = deq_pkg::ST_EMPTY;
          info_next.err    = 1'b1;
        end else begin
          rd_en        = op_en;
          rd_addr      = rear_dec;
          info_next.rd = 1'b1;
          if (mode == deq_pkg::OP_POP_REAR) begin
            rear_next  = rear_dec;
            count_next = count - 1'b1;
          end
        end
      end
      deq_pkg::OP_CLEAR: begin
        front_next = '0;
        rear_next  = '0;
        count_next = '0;
      end
      default: begin
        // unused code leaves the deque as it is
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front       <= '0;
      rear        <= '0;
      count       <= '0;
      info.status <= deq_pkg::ST_OK;
      info.rd     <= 1'b0;
      info.err    <= 1'b0;
    end else if (op_en) begin
      front <= front_next;
      rear  <= rear_next;
      count <= count_next;
      info  <= info_next;
    end
  end

endmodule

// ----- sv/double_ended_queue.sv -----
// Bounded double-ended queue of signed words kept in a ring-buffer RAM.
// Input beat: s_tuser carries the operation (push front, push rear, pop front,
// pop rear, peek front, peek rear, clear), s_tdata the word to push.
// Output beat: one per input beat, carrying the word read (-1 on an empty
// error, 0 when nothing is read), the status on m_tuser (ok, empty, full),
// the empty and full flags and the element count after the operation.
// The index update and the RAM read are issued at acceptance, and the RAM's
// registered read port supplies the word on the next cycle, together with
// m_tvalid. One beat may be accepted every cycle while the output is not
// stalled; the single RAM read port and one write port per cycle allow it.
// Writes land before any later read, so no forwarding path is needed.
// When m_tready is low the result is held and s_tready drops until the
// beat is taken; the RAM read data stays put as no new read is issued.
// Reset empties the queue (indices and count to zero); store contents are
// left as they are and are never read before being written.
// depends on deq_pkg, deq_ctrl, deq_ram
module double_ended_queue #(
  parameter int DEPTH      = deq_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = deq_pkg::DATA_WIDTH_DEF,
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CNT_W = $clog2(DEPTH + 1),
  localparam int OUT_W = ((deq_pkg::DATA_OUT_W + 2 + CNT_W + 7) / 8) * 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [deq_pkg::VALUE_W-1:0]   s_tdata,  // value
  input  logic [deq_pkg::MODE_W-1:0]    s_tuser,  // mode
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [OUT_W-1:0]              m_tdata,  // data, empty_flag, full_flag, count, zero pad
  output logic [deq_pkg::STATUS_W-1:0]  m_tuser   // status
);

  logic                  accept;
  logic                  wr_en, rd_en;
  logic [IDX_W-1:0]      wr_addr, rd_addr;
  logic [DATA_WIDTH-1:0] wr_data, rd_data;
  deq_pkg::res_info_t    info;
  logic [CNT_W-1:0]      count;
  logic [deq_pkg::DATA_OUT_W-1:0] rd_word, data;
  logic                  empty_flag, full_flag;

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  deq_ctrl #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .op_en   (accept),
    .mode    (s_tuser),
    .value   (s_tdata),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .info    (info),
    .count   (count)
  );

  deq_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // stored word brought to the output width: sign-extended or cut
  generate
    if (DATA_WIDTH >= deq_pkg::DATA_OUT_W) begin : g_cut
      assign rd_word = rd_data[deq_pkg::DATA_OUT_W-1:0];
    end else begin : g_ext
      assign rd_word = {{(deq_pkg::DATA_OUT_W - DATA_WIDTH){rd_data[DATA_WIDTH-1]}}, rd_data};
    end
  endgenerate

  always_comb begin
    if (info.rd) begin
      data = rd_word;
    end else if (info.err) begin
      data = '1;
    end else begin
      data = '0;
    end
  end

  assign empty_flag = (count == '0);
  assign full_flag  = (count == CNT_W'(DEPTH));
  assign m_tdata    = OUT_W'({count, full_flag, empty_flag, data});
  assign m_tuser    = info.status;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s_tready) begin
      m_tvalid <= s_tvalid;
    end
  end

endmodule
